// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands for the checker file srv_checker.sv.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge, skip while reset is low.
`define SRV_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Flag an expression that must never be true outside reset.
`define SRV_ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
  `SRV_ASSERT(lbl, clk, rst_n, !(expr), msg)

`endif

// ===== rtl/core/srv_pkg.sv =====
// ----------------------------------------------------------------------------
// srv_pkg
// Shared widths, width helpers and the sideband word of the refraction pipe.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package srv_pkg;

  localparam int unsigned FRAC_BITS_DEF = 14;
  localparam int unsigned DATA_W        = 16;
  localparam int unsigned RATIO_W       = 16;
  // r * (I*one - N*c) rounded by FRAC_BITS keeps this width for any FRAC_BITS
  localparam int unsigned W_W           = DATA_W + RATIO_W + 6;

  // signed width of the discriminant 1 - round(r*r*s)
  function automatic int unsigned disc_w(input int unsigned f);
    int unsigned a;
    int unsigned b;
    a = 2 * RATIO_W + 7 - f;
    b = f + 2;
    return ((a > b) ? a : b) + 1;
  endfunction

  // square-root radicand width (discriminant shifted up by f), made even
  function automatic int unsigned rad_w(input int unsigned f);
    int unsigned n;
    n = disc_w(f) - 1 + f;
    return n + (n % 2);
  endfunction

  // width of the floor square root
  function automatic int unsigned sq_w(input int unsigned f);
    return rad_w(f) / 2;
  endfunction

  // words that ride alongside the square root
  typedef struct packed {
    logic                     ok;
    logic signed [W_W-1:0]    w_x;
    logic signed [W_W-1:0]    w_y;
    logic signed [W_W-1:0]    w_z;
    logic signed [DATA_W-1:0] n_x;
    logic signed [DATA_W-1:0] n_y;
    logic signed [DATA_W-1:0] n_z;
  } side_t;

endpackage

// ===== rtl/core/srv_front.sv =====
// ----------------------------------------------------------------------------
// srv_front
// Six-stage front end: dot product, discriminant and the tangential term.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module srv_front #(
  parameter int unsigned FRAC_BITS = srv_pkg::FRAC_BITS_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic signed [srv_pkg::DATA_W-1:0]     inc_i [3],
  input  logic signed [srv_pkg::DATA_W-1:0]     nrm_i [3],
  input  logic [srv_pkg::RATIO_W-1:0]           ratio_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic [srv_pkg::rad_w(FRAC_BITS)-1:0]  rad_o,
  output srv_pkg::side_t                        side_o
);

  localparam int unsigned F      = FRAC_BITS;
  localparam int unsigned NST    = 6;
  localparam int unsigned DW     = srv_pkg::DATA_W;
  localparam int unsigned RW     = srv_pkg::RATIO_W;
  localparam int unsigned WW     = srv_pkg::W_W;
  localparam int unsigned P_W    = 2 * DW;
  localparam int unsigned DOT_W  = 2 * DW + 2;
  localparam int unsigned C_W    = F + 4;
  localparam int unsigned CC_W   = 2 * C_W;
  localparam int unsigned NC_W   = DW + C_W;
  localparam int unsigned S1_W   = F + 6;
  localparam int unsigned RR_W   = 2 * RW;
  localparam int unsigned RRS_W  = RR_W + 1 + S1_W;
  localparam int unsigned X_W    = RRS_W - 2 * F;
  localparam int unsigned U_W    = DW + F + 5;
  localparam int unsigned RU_W   = U_W + RW + 1;
  localparam int unsigned DISC_W = srv_pkg::disc_w(F);
  localparam int unsigned RAD_W  = srv_pkg::rad_w(F);

  localparam logic signed [DOT_W-1:0]  DOT_HALF = DOT_W'(1) <<< (F - 1);
  localparam logic signed [DOT_W-1:0]  C_HI     = DOT_W'(4) <<< F;
  localparam logic signed [DOT_W-1:0]  C_LO     = -C_HI;
  localparam logic signed [CC_W-1:0]   S_ONE    = CC_W'(1) <<< (2 * F);
  localparam logic signed [CC_W-1:0]   S_HALF   = CC_W'(1) <<< (F - 1);
  localparam logic signed [RRS_W-1:0]  RRS_HALF = RRS_W'(1) <<< (2 * F - 1);
  localparam logic signed [RU_W-1:0]   RU_HALF  = RU_W'(1) <<< (F - 1);
  localparam logic signed [DISC_W-1:0] D_ONE    = DISC_W'(1) <<< F;

  // stage valid bits and advance chain
  logic [NST-1:0] vld_q;
  logic [NST-1:0] vld_d;
  logic [NST:0]   adv;

  assign adv[NST] = out_ready_i;
  for (genvar g = 0; g < NST; g++) begin : g_adv
    assign adv[g] = !vld_q[g] || adv[g+1];
  end
  assign vld_d = {vld_q[NST-2:0], in_valid_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int i = 0; i < NST; i++) begin
        if (adv[i]) begin
          vld_q[i] <= vld_d[i];
        end
      end
    end
  end

  assign in_ready_o  = adv[0];
  assign out_valid_o = vld_q[NST-1];

  // stage 1: component products and r*r
  logic signed [P_W-1:0]  p1_q [3];
  logic signed [DW-1:0]   inc1_q [3];
  logic signed [DW-1:0]   nrm1_q [3];
  logic [RW-1:0]          ratio1_q;
  logic [RR_W-1:0]        rr1_q;

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      for (int k = 0; k < 3; k++) begin
        p1_q[k]   <= P_W'(inc_i[k]) * P_W'(nrm_i[k]);
        inc1_q[k] <= inc_i[k];
        nrm1_q[k] <= nrm_i[k];
      end
      ratio1_q <= ratio_i;
      rr1_q    <= RR_W'(ratio_i) * RR_W'(ratio_i);
    end
  end

  // stage 2: sum, round, clamp to +-4.0
  logic signed [DOT_W-1:0] dot;
  logic signed [DOT_W-1:0] c_full;
  logic signed [C_W-1:0]   c_d;
  logic signed [C_W-1:0]   c2_q;
  logic signed [DW-1:0]    inc2_q [3];
  logic signed [DW-1:0]    nrm2_q [3];
  logic [RW-1:0]           ratio2_q;
  logic [RR_W-1:0]         rr2_q;

  always_comb begin
    dot    = DOT_W'(p1_q[0]) + DOT_W'(p1_q[1]) + DOT_W'(p1_q[2]) + DOT_HALF;
    c_full = dot >>> F;
    if (c_full > C_HI) begin
      c_d = C_W'(C_HI);
    end else if (c_full < C_LO) begin
      c_d = C_W'(C_LO);
    end else begin
      c_d = C_W'(c_full);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[1]) begin
      c2_q     <= c_d;
      inc2_q   <= inc1_q;
      nrm2_q   <= nrm1_q;
      ratio2_q <= ratio1_q;
      rr2_q    <= rr1_q;
    end
  end

  // stage 3: c*c and N*c
  logic signed [CC_W-1:0] cc3_q;
  logic signed [NC_W-1:0] nc3_q [3];
  logic signed [DW-1:0]   inc3_q [3];
  logic signed [DW-1:0]   nrm3_q [3];
  logic [RW-1:0]          ratio3_q;
  logic [RR_W-1:0]        rr3_q;

  always_ff @(posedge clk_i) begin
    if (adv[2]) begin
      cc3_q <= CC_W'(c2_q) * CC_W'(c2_q);
      for (int k = 0; k < 3; k++) begin
        nc3_q[k] <= NC_W'(nrm2_q[k]) * NC_W'(c2_q);
      end
      inc3_q   <= inc2_q;
      nrm3_q   <= nrm2_q;
      ratio3_q <= ratio2_q;
      rr3_q    <= rr2_q;
    end
  end

  // stage 4: s = 1 - c*c rounded, u = I*one - N*c
  logic signed [CC_W-1:0] s_full;
  logic signed [S1_W-1:0] s1_q;
  logic signed [U_W-1:0]  u4_q [3];
  logic signed [DW-1:0]   nrm4_q [3];
  logic [RW-1:0]          ratio4_q;
  logic [RR_W-1:0]        rr4_q;

  assign s_full = S_ONE - cc3_q + S_HALF;

  always_ff @(posedge clk_i) begin
    if (adv[3]) begin
      s1_q <= s_full[F+S1_W-1:F];
      for (int k = 0; k < 3; k++) begin
        u4_q[k] <= (U_W'(inc3_q[k]) <<< F) - U_W'(nc3_q[k]);
      end
      nrm4_q   <= nrm3_q;
      ratio4_q <= ratio3_q;
      rr4_q    <= rr3_q;
    end
  end

  // stage 5: r*r*s and r*u
  logic signed [RRS_W-1:0] rrs5_q;
  logic signed [RU_W-1:0]  ru5_q [3];
  logic signed [DW-1:0]    nrm5_q [3];

  always_ff @(posedge clk_i) begin
    if (adv[4]) begin
      rrs5_q <= RRS_W'($signed({1'b0, rr4_q})) * RRS_W'(s1_q);
      for (int k = 0; k < 3; k++) begin
        ru5_q[k] <= RU_W'($signed({1'b0, ratio4_q})) * RU_W'(u4_q[k]);
      end
      nrm5_q <= nrm4_q;
    end
  end

  // stage 6: discriminant, flag, radicand, rounded tangential term
  logic signed [RRS_W-1:0]  rrs_rnd;
  logic signed [X_W-1:0]    x_rnd;
  logic signed [DISC_W-1:0] disc;
  logic                     ok;
  logic signed [RU_W-1:0]   ru_rnd [3];
  logic signed [WW-1:0]     w_d [3];
  logic [RAD_W-1:0]         rad_q;
  logic                     ok_q;
  logic signed [WW-1:0]     w_q [3];
  logic signed [DW-1:0]     nrm6_q [3];

  always_comb begin
    rrs_rnd = rrs5_q + RRS_HALF;
    x_rnd   = rrs_rnd[RRS_W-1:2*F];
    disc    = D_ONE - DISC_W'(x_rnd);
    ok      = !disc[DISC_W-1] && (disc != '0);
    for (int k = 0; k < 3; k++) begin
      ru_rnd[k] = ru5_q[k] + RU_HALF;
      w_d[k]    = ru_rnd[k][RU_W-1:F];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[5]) begin
      ok_q   <= ok;
      // drop the radicand on total internal reflection
      rad_q  <= ok ? RAD_W'({disc[DISC_W-2:0], {F{1'b0}}}) : '0;
      w_q    <= w_d;
      nrm6_q <= nrm5_q;
    end
  end

  assign rad_o       = rad_q;
  assign side_o.ok   = ok_q;
  assign side_o.w_x  = w_q[0];
  assign side_o.w_y  = w_q[1];
  assign side_o.w_z  = w_q[2];
  assign side_o.n_x  = nrm6_q[0];
  assign side_o.n_y  = nrm6_q[1];
  assign side_o.n_z  = nrm6_q[2];

endmodule

// ===== rtl/core/srv_sqrt.sv =====
// ----------------------------------------------------------------------------
// srv_sqrt
// Pipelined floor square root, one root bit per stage, sideband carried along.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module srv_sqrt #(
  parameter int unsigned FRAC_BITS = srv_pkg::FRAC_BITS_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic [srv_pkg::rad_w(FRAC_BITS)-1:0]  in_rad_i,
  input  srv_pkg::side_t                        in_side_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic [srv_pkg::sq_w(FRAC_BITS)-1:0]   out_root_o,
  output srv_pkg::side_t                        out_side_o
);

  localparam int unsigned SQ_W  = srv_pkg::sq_w(FRAC_BITS);
  localparam int unsigned RAD_W = srv_pkg::rad_w(FRAC_BITS);
  localparam int unsigned REM_W = SQ_W + 2;
  localparam int unsigned NS    = SQ_W;

  logic [NS-1:0]      vld_q;
  logic [NS:0]        adv;
  logic [REM_W-1:0]   rem_q   [NS];
  logic [SQ_W-1:0]    root_q  [NS];
  logic [RAD_W-1:0]   rad_q   [NS];
  srv_pkg::side_t     side_q  [NS];

  logic [NS-1:0]      vld_in;
  logic [REM_W-1:0]   rem_in  [NS];
  logic [SQ_W-1:0]    root_in [NS];
  logic [RAD_W-1:0]   rad_in  [NS];
  srv_pkg::side_t     side_in [NS];
  logic [REM_W+1:0]   rem_sh  [NS];
  logic [REM_W+1:0]   trial   [NS];
  logic [NS-1:0]      fit;

  assign adv[NS] = out_ready_i;

  for (genvar g = 0; g < NS; g++) begin : g_stage
    if (g == 0) begin : g_first
      assign vld_in[g]  = in_valid_i;
      assign rem_in[g]  = '0;
      assign root_in[g] = '0;
      assign rad_in[g]  = in_rad_i;
      assign side_in[g] = in_side_i;
    end else begin : g_next
      assign vld_in[g]  = vld_q[g-1];
      assign rem_in[g]  = rem_q[g-1];
      assign root_in[g] = root_q[g-1];
      assign rad_in[g]  = rad_q[g-1];
      assign side_in[g] = side_q[g-1];
    end

    assign adv[g]    = !vld_q[g] || adv[g+1];
    // bring down the next two radicand bits, try root*4 + 1
    assign rem_sh[g] = {rem_in[g], rad_in[g][RAD_W-1 -: 2]};
    assign trial[g]  = (REM_W + 2)'({root_in[g], 2'b01});
    assign fit[g]    = rem_sh[g] >= trial[g];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[g] <= 1'b0;
      end else if (adv[g]) begin
        vld_q[g] <= vld_in[g];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv[g]) begin
        rem_q[g]  <= fit[g] ? REM_W'(rem_sh[g] - trial[g]) : REM_W'(rem_sh[g]);
        root_q[g] <= {root_in[g][SQ_W-2:0], fit[g]};
        rad_q[g]  <= rad_in[g] << 2;
        side_q[g] <= side_in[g];
      end
    end
  end

  assign in_ready_o  = adv[0];
  assign out_valid_o = vld_q[NS-1];
  assign out_root_o  = root_q[NS-1];
  assign out_side_o  = side_q[NS-1];

endmodule

// ===== rtl/core/srv_back.sv =====
// ----------------------------------------------------------------------------
// srv_back
// Back end: subtract the normal scaled by the root, round, saturate, zero on
// total internal reflection. The last stage is the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module srv_back #(
  parameter int unsigned FRAC_BITS = srv_pkg::FRAC_BITS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [srv_pkg::sq_w(FRAC_BITS)-1:0]  in_root_i,
  input  srv_pkg::side_t                       in_side_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic                                 out_ok_o,
  output logic signed [srv_pkg::DATA_W-1:0]    out_vec_o [3]
);

  localparam int unsigned F      = FRAC_BITS;
  localparam int unsigned DW     = srv_pkg::DATA_W;
  localparam int unsigned WW     = srv_pkg::W_W;
  localparam int unsigned SQ_W   = srv_pkg::sq_w(FRAC_BITS);
  localparam int unsigned NVSQ_W = DW + SQ_W + 1;
  localparam int unsigned D_W    = ((WW > NVSQ_W) ? WW : NVSQ_W) + 2;
  localparam int unsigned T_W    = D_W - F;

  localparam logic signed [D_W-1:0] D_HALF = D_W'(1) <<< (F - 1);
  localparam logic signed [T_W-1:0] T_MAX  = T_W'((1 << (DW - 1)) - 1);
  localparam logic signed [T_W-1:0] T_MIN  = ~T_MAX;

  logic [1:0] vld_q;
  logic [2:0] adv;

  assign adv[2] = out_ready_i;
  assign adv[1] = !vld_q[1] || adv[2];
  assign adv[0] = !vld_q[0] || adv[1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (adv[0]) begin
        vld_q[0] <= in_valid_i;
      end
      if (adv[1]) begin
        vld_q[1] <= vld_q[0];
      end
    end
  end

  assign in_ready_o  = adv[0];
  assign out_valid_o = vld_q[1];

  // stage 1: N * sqrt(D)
  logic signed [DW-1:0]     nrm  [3];
  logic signed [WW-1:0]     w_in [3];
  logic                     ok1_q;
  logic signed [WW-1:0]     w1_q    [3];
  logic signed [NVSQ_W-1:0] nvsq1_q [3];

  assign nrm[0]  = in_side_i.n_x;
  assign nrm[1]  = in_side_i.n_y;
  assign nrm[2]  = in_side_i.n_z;
  assign w_in[0] = in_side_i.w_x;
  assign w_in[1] = in_side_i.w_y;
  assign w_in[2] = in_side_i.w_z;

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      ok1_q <= in_side_i.ok;
      for (int k = 0; k < 3; k++) begin
        w1_q[k]    <= w_in[k];
        nvsq1_q[k] <= NVSQ_W'(nrm[k]) * NVSQ_W'($signed({1'b0, in_root_i}));
      end
    end
  end

  // stage 2: round, saturate, zero if no refraction
  logic signed [D_W-1:0] diff [3];
  logic signed [T_W-1:0] t    [3];
  logic signed [DW-1:0]  vec_d [3];
  logic                  ok_q;
  logic signed [DW-1:0]  vec_q [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      diff[k] = D_W'(w1_q[k]) - D_W'(nvsq1_q[k]) + D_HALF;
      t[k]    = diff[k][D_W-1:F];
      if (!ok1_q) begin
        vec_d[k] = '0;
      end else if (t[k] > T_MAX) begin
        vec_d[k] = DW'(T_MAX);
      end else if (t[k] < T_MIN) begin
        vec_d[k] = DW'(T_MIN);
      end else begin
        vec_d[k] = DW'(t[k]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[1]) begin
      ok_q  <= ok1_q;
      vec_q <= vec_d;
    end
  end

  assign out_ok_o  = ok_q;
  assign out_vec_o = vec_q;

endmodule

// ===== rtl/core/snell_refraction_vector.sv =====
// ----------------------------------------------------------------------------
// snell_refraction_vector
// Refracts a direction vector at a surface by Snell's law, in signed fixed
// point with FRAC_BITS fraction bits (Q2.14 by default), saturating outputs.
//
// Usage:
//   Input channel (in_valid_i / in_ready_o) takes one word per ray: incident
//   direction, surface normal and the index ratio (incident over refracted).
//   Output channel (out_valid_o / out_ready_i) returns one word per ray: the
//   refracted_ok_o flag and the refracted vector, zero when the ray is
//   totally internally reflected.
//   Throughput: one word per cycle while the receiver keeps up.
//   Pipeline: the floor square root resolves one root bit per pipeline
//   stage; six front stages and two back stages surround it.
//   Reset: all stage valid bits clear, so the pipe comes up empty and ready.
//   Receiver stall: words hold in place; upstream stages keep advancing into
//   empty slots, and in_ready_o drops only once every stage holds a word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module snell_refraction_vector #(
  parameter int unsigned FRAC_BITS = srv_pkg::FRAC_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // input word
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic signed [srv_pkg::DATA_W-1:0]  incidence_x_i,
  input  logic signed [srv_pkg::DATA_W-1:0]  incidence_y_i,
  input  logic signed [srv_pkg::DATA_W-1:0]  incidence_z_i,
  input  logic signed [srv_pkg::DATA_W-1:0]  normal_x_i,
  input  logic signed [srv_pkg::DATA_W-1:0]  normal_y_i,
  input  logic signed [srv_pkg::DATA_W-1:0]  normal_z_i,
  input  logic [srv_pkg::RATIO_W-1:0]        index_ratio_i,
  // output word
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic                               refracted_ok_o,
  output logic signed [srv_pkg::DATA_W-1:0]  refracted_x_o,
  output logic signed [srv_pkg::DATA_W-1:0]  refracted_y_o,
  output logic signed [srv_pkg::DATA_W-1:0]  refracted_z_o
);

  localparam int unsigned DW    = srv_pkg::DATA_W;
  localparam int unsigned SQ_W  = srv_pkg::sq_w(FRAC_BITS);
  localparam int unsigned RAD_W = srv_pkg::rad_w(FRAC_BITS);

  // gather the axes into arrays for the per-axis datapaths
  logic signed [DW-1:0] inc [3];
  logic signed [DW-1:0] nrm [3];
  logic signed [DW-1:0] vec [3];

  assign inc[0] = incidence_x_i;
  assign inc[1] = incidence_y_i;
  assign inc[2] = incidence_z_i;
  assign nrm[0] = normal_x_i;
  assign nrm[1] = normal_y_i;
  assign nrm[2] = normal_z_i;

  // front end -> square root
  logic             fr_valid;
  logic             fr_ready;
  logic [RAD_W-1:0] fr_rad;
  srv_pkg::side_t   fr_side;

  // square root -> back end
  logic             sq_valid;
  logic             sq_ready;
  logic [SQ_W-1:0]  sq_root;
  srv_pkg::side_t   sq_side;

  // dot product, discriminant, flag, tangential term
  srv_front #(
    .FRAC_BITS (FRAC_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .inc_i       (inc),
    .nrm_i       (nrm),
    .ratio_i     (index_ratio_i),
    .out_valid_o (fr_valid),
    .out_ready_i (fr_ready),
    .rad_o       (fr_rad),
    .side_o      (fr_side)
  );

  // sqrt(D) with FRAC_BITS fraction bits, sideband travels in lockstep
  srv_sqrt #(
    .FRAC_BITS (FRAC_BITS)
  ) u_sqrt (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (fr_valid),
    .in_ready_o  (fr_ready),
    .in_rad_i    (fr_rad),
    .in_side_i   (fr_side),
    .out_valid_o (sq_valid),
    .out_ready_i (sq_ready),
    .out_root_o  (sq_root),
    .out_side_o  (sq_side)
  );

  // combine, round, saturate; holds the output register
  srv_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (sq_valid),
    .in_ready_o  (sq_ready),
    .in_root_i   (sq_root),
    .in_side_i   (sq_side),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_ok_o    (refracted_ok_o),
    .out_vec_o   (vec)
  );

  assign refracted_x_o = vec[0];
  assign refracted_y_o = vec[1];
  assign refracted_z_o = vec[2];

endmodule

// ===== rtl/core/srv_checker.sv =====
// ----------------------------------------------------------------------------
// srv_checker
// Port-level checks on the refraction block, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module srv_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_valid_i,
  input logic                              in_ready_o,
  input logic                              out_valid_o,
  input logic                              out_ready_i,
  input logic                              refracted_ok_o,
  input logic signed [srv_pkg::DATA_W-1:0] refracted_x_o,
  input logic signed [srv_pkg::DATA_W-1:0] refracted_y_o,
  input logic signed [srv_pkg::DATA_W-1:0] refracted_z_o
);

  localparam int unsigned CNT_W = 8;

  // words accepted but not yet delivered
  logic [CNT_W-1:0] cnt_q;
  logic [CNT_W-1:0] cnt_d;
  logic             in_acc;
  logic             out_acc;

  assign in_acc  = in_valid_i && in_ready_o;
  assign out_acc = out_valid_o && out_ready_i;

  always_comb begin
    cnt_d = cnt_q;
    if (in_acc && !out_acc) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (out_acc && !in_acc) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  `SRV_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i |=> out_valid_o, "output word dropped while stalled")
  `SRV_ASSERT(a_out_stable, clk_i, rst_ni, out_valid_o && !out_ready_i |=> $stable(refracted_ok_o) && $stable(refracted_x_o) && $stable(refracted_y_o) && $stable(refracted_z_o), "output word changed while stalled")
  `SRV_ASSERT(a_tir_zero, clk_i, rst_ni, out_valid_o && !refracted_ok_o |-> refracted_x_o == '0 && refracted_y_o == '0 && refracted_z_o == '0, "nonzero vector on total internal reflection")
  `SRV_ASSERT_NEVER(a_no_phantom, clk_i, rst_ni, out_valid_o && cnt_q == '0, "output word without an accepted input word")

endmodule

bind snell_refraction_vector srv_checker u_srv_checker (.*);

// ===== verif/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for snell_refraction_vector. A directed table (zero
// vectors, normal and grazing incidence, total internal reflection, dot
// products that saturate, field extremes) runs first. Random rays follow,
// mostly unit vectors at physical index ratios plus raw and edge values. Every
// result word is checked in order by a typed word or a fixed-point predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned DATA_W      = srv_pkg::DATA_W;
  localparam int unsigned RATIO_W     = srv_pkg::RATIO_W;
  localparam int unsigned FRAC        = srv_pkg::FRAC_BITS_DEF;
  localparam int          ONE         = 1 << FRAC;
  localparam int unsigned PIPE_DEPTH  = 7 + srv_pkg::sq_w(FRAC);
  localparam int          IDLE_PCT    = 38;
  localparam int          RANDOM_RAYS = 800;
  localparam int          PAUSE_AT    = 300;
  localparam int          STEADY_LO   = 450;
  localparam int          STEADY_HI   = 600;
  localparam int          LIMIT_CYCLES = 400000;
  localparam int          N_DIRECTED  = 18;

  // one incoming ray and one refracted word, at the port widths
  typedef struct packed {
    logic signed [DATA_W-1:0] ix;
    logic signed [DATA_W-1:0] iy;
    logic signed [DATA_W-1:0] iz;
    logic signed [DATA_W-1:0] nx;
    logic signed [DATA_W-1:0] ny;
    logic signed [DATA_W-1:0] nz;
    logic [RATIO_W-1:0]       ratio;
  } ray_t;

  typedef struct packed {
    logic                     ok;
    logic signed [DATA_W-1:0] tx;
    logic signed [DATA_W-1:0] ty;
    logic signed [DATA_W-1:0] tz;
  } bend_t;

  // known = 1: the expected word is written in the row, else it is predicted
  typedef struct packed {
    ray_t  ray;
    bit    known;
    bend_t want;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                     in_valid_i = 1'b0;
  logic                     in_ready_o;
  logic signed [DATA_W-1:0] incidence_x_i = '0;
  logic signed [DATA_W-1:0] incidence_y_i = '0;
  logic signed [DATA_W-1:0] incidence_z_i = '0;
  logic signed [DATA_W-1:0] normal_x_i = '0;
  logic signed [DATA_W-1:0] normal_y_i = '0;
  logic signed [DATA_W-1:0] normal_z_i = '0;
  logic [RATIO_W-1:0]       index_ratio_i = '0;
  logic                     out_valid_o;
  logic                     out_ready_i = 1'b0;
  logic                     refracted_ok_o;
  logic signed [DATA_W-1:0] refracted_x_o;
  logic signed [DATA_W-1:0] refracted_y_o;
  logic signed [DATA_W-1:0] refracted_z_o;

  bend_t expected_bends[$];
  int    mismatches = 0;
  int    cycles = 0;
  bit    steady = 1'b0;

  // Directed rays. Rows with a typed word are the ones whose answer is plain:
  // zero vectors, head-on incidence, grazing rays that hit D = 0 or go
  // totally internally reflected. The rest go through the predictor.
  row_t directed_rows [N_DIRECTED] = '{
    // all zero, ratio zero: D = 1, vector zero
    '{'{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'd0}, 1'b1,
      '{1'b1, 16'sd0, 16'sd0, 16'sd0}},
    // ratio zero along the normal: result is minus the normal
    '{'{16'sd0, 16'sd0, 16'(ONE), 16'sd0, 16'sd0, 16'(ONE), 16'd0}, 1'b1,
      '{1'b1, 16'sd0, 16'sd0, 16'(-ONE)}},
    // head-on, matched indices: the ray goes straight through
    '{'{16'sd0, 16'sd0, 16'(-ONE), 16'sd0, 16'sd0, 16'(ONE), 16'(ONE)}, 1'b1,
      '{1'b1, 16'sd0, 16'sd0, 16'(-ONE)}},
    // grazing, matched indices: D lands exactly on zero, so no refraction
    '{'{16'(ONE), 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'(ONE), 16'(ONE)}, 1'b1,
      '{1'b0, 16'sd0, 16'sd0, 16'sd0}},
    // grazing at ratio 2.0: total internal reflection
    '{'{16'(ONE), 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'(ONE), 16'(2 * ONE)}, 1'b1,
      '{1'b0, 16'sd0, 16'sd0, 16'sd0}},
    // grazing at the largest ratio: total internal reflection
    '{'{16'(ONE), 16'sd0, 16'sd0, 16'sd0, 16'(ONE), 16'sd0, 16'hFFFF}, 1'b1,
      '{1'b0, 16'sd0, 16'sd0, 16'sd0}},
    // zero normal at ratio 1.0: D = 0 whatever the incident vector
    '{'{16'sd32767, -16'sd32768, 16'sd12345, 16'sd0, 16'sd0, 16'sd0, 16'(ONE)},
      1'b1, '{1'b0, 16'sd0, 16'sd0, 16'sd0}},
    // zero normal just below ratio 1.0: a small positive discriminant
    '{'{16'sd32767, -16'sd32768, 16'sd12345, 16'sd0, 16'sd0, 16'sd0,
        16'(ONE - 1)}, 1'b0, '0},
    // 45 degrees, air into glass
    '{'{16'sd11585, 16'sd0, -16'sd11585, 16'sd0, 16'sd0, 16'(ONE), 16'd10923},
      1'b0, '0},
    // 45 degrees, glass into air: past the critical angle
    '{'{16'sd11585, 16'sd0, -16'sd11585, 16'sd0, 16'sd0, 16'(ONE), 16'd24576},
      1'b0, '0},
    // dot product saturates high, largest ratio, outputs saturate
    '{'{16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767,
        16'hFFFF}, 1'b0, '0},
    // dot product saturates low, ratio zero
    '{'{-16'sd32768, -16'sd32768, -16'sd32768, 16'sd32767, 16'sd32767,
        16'sd32767, 16'd0}, 1'b0, '0},
    // most negative everywhere, largest ratio
    '{'{-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768,
        -16'sd32768, 16'hFFFF}, 1'b0, '0},
    // alternating extremes
    '{'{16'sd32767, -16'sd32768, 16'sd32767, -16'sd32768, 16'sd32767,
        -16'sd32768, 16'hFFFF}, 1'b0, '0},
    // dot lands exactly on the 4.0 clamp
    '{'{-16'sd32768, 16'sd0, 16'sd0, -16'sd32768, 16'sd0, 16'sd0, 16'hFFFF},
      1'b0, '0},
    // tiny vectors, smallest nonzero ratio
    '{'{16'sd1, -16'sd1, 16'sd1, -16'sd1, 16'sd1, -16'sd1, 16'd1}, 1'b0, '0},
    // incident twice unit length: dot of -2.0, s negative
    '{'{16'sd0, 16'sd0, 16'(-2 * ONE), 16'sd0, 16'sd0, 16'(ONE), 16'(ONE)},
      1'b0, '0},
    // oblique, ratio 1.5 from below the critical angle
    '{'{16'sd4000, -16'sd3000, -16'sd15600, 16'sd0, 16'sd0, 16'(ONE),
        16'd24576}, 1'b0, '0}
  };

  snell_refraction_vector dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .incidence_x_i  (incidence_x_i),
    .incidence_y_i  (incidence_y_i),
    .incidence_z_i  (incidence_z_i),
    .normal_x_i     (normal_x_i),
    .normal_y_i     (normal_y_i),
    .normal_z_i     (normal_z_i),
    .index_ratio_i  (index_ratio_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .refracted_ok_o (refracted_ok_o),
    .refracted_x_o  (refracted_x_o),
    .refracted_y_o  (refracted_y_o),
    .refracted_z_o  (refracted_z_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------- predictor

  // round half up: add half the dropped weight, then floor
  function automatic longint round_sh(input longint v, input int unsigned s);
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function automatic longint clamp(input longint v, input longint lo,
                                   input longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // bit-pair floor square root
  function automatic longint unsigned floor_root(input longint unsigned v);
    longint unsigned root;
    longint unsigned probe;
    root = 0;
    probe = longint'(1) << 62;
    while (probe > v) probe = probe >> 2;
    while (probe != 0) begin
      if (v >= root + probe) begin
        v = v - (root + probe);
        root = (root >> 1) + probe;
      end else begin
        root = root >> 1;
      end
      probe = probe >> 2;
    end
    return root;
  endfunction

  // T = r*(I - N*c) - N*sqrt(D), with c = dot(I, N), D = 1 - r*r*(1 - c*c)
  function automatic bend_t refract(input ray_t ray);
    longint                   iv [3];
    longint                   nv [3];
    longint                   r;
    longint                   c;
    longint                   s1;
    longint                   disc;
    longint                   sq;
    longint                   w;
    logic signed [DATA_W-1:0] tv [3];
    bend_t                    res;
    iv[0] = longint'(ray.ix);
    iv[1] = longint'(ray.iy);
    iv[2] = longint'(ray.iz);
    nv[0] = longint'(ray.nx);
    nv[1] = longint'(ray.ny);
    nv[2] = longint'(ray.nz);
    r = longint'(ray.ratio);
    c = clamp(round_sh(iv[0] * nv[0] + iv[1] * nv[1] + iv[2] * nv[2], FRAC),
              -4 * ONE, 4 * ONE);
    s1 = round_sh((longint'(1) << (2 * FRAC)) - c * c, FRAC);
    disc = ONE - round_sh(r * r * s1, 2 * FRAC);
    res = '0;
    if (disc <= 0) return res;
    sq = longint'(floor_root(longint'(disc) << FRAC));
    for (int k = 0; k < 3; k++) begin
      w = round_sh(r * (iv[k] * ONE - nv[k] * c), FRAC);
      tv[k] = DATA_W'(clamp(round_sh(w - nv[k] * sq, FRAC), -32768, 32767));
    end
    res.ok = 1'b1;
    res.tx = tv[0];
    res.ty = tv[1];
    res.tz = tv[2];
    return res;
  endfunction

  // ---------------------------------------------------------------- stimulus

  // random direction of unit length, as {x, y, z}
  function automatic logic [3*DATA_W-1:0] draw_unit();
    real a;
    real b;
    real c;
    real len;
    a = real'(int'($urandom_range(0, 2000))) - 1000.0;
    b = real'(int'($urandom_range(0, 2000))) - 1000.0;
    c = real'(int'($urandom_range(0, 2000))) - 1000.0;
    len = $sqrt(a * a + b * b + c * c);
    if (len < 1.0) begin
      a = 0.0;
      b = 0.0;
      c = 1.0;
      len = 1.0;
    end
    return {DATA_W'($rtoi(a / len * ONE)), DATA_W'($rtoi(b / len * ONE)),
            DATA_W'($rtoi(c / len * ONE))};
  endfunction

  function automatic logic [DATA_W-1:0] edge_value();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return DATA_W'(1);
      2: return '1;
      3: return DATA_W'(16'h7FFF);
      4: return DATA_W'(16'h8000);
      5: return DATA_W'(ONE);
      6: return DATA_W'(-ONE);
      default: return DATA_W'($urandom);
    endcase
  endfunction

  // mostly unit vectors at physical ratios; the rest raw bits or edge values
  function automatic ray_t draw_ray();
    ray_t        ray;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 60) begin
      {ray.ix, ray.iy, ray.iz} = draw_unit();
      {ray.nx, ray.ny, ray.nz} = draw_unit();
      ray.ratio = RATIO_W'($urandom_range(ONE * 2 / 5, ONE * 5 / 2));
    end else if (pick < 80) begin
      ray.ix = DATA_W'($urandom);
      ray.iy = DATA_W'($urandom);
      ray.iz = DATA_W'($urandom);
      ray.nx = DATA_W'($urandom);
      ray.ny = DATA_W'($urandom);
      ray.nz = DATA_W'($urandom);
      ray.ratio = RATIO_W'($urandom);
    end else begin
      ray.ix = edge_value();
      ray.iy = edge_value();
      ray.iz = edge_value();
      ray.nx = edge_value();
      ray.ny = edge_value();
      ray.nz = edge_value();
      ray.ratio = edge_value();
    end
    return ray;
  endfunction

  // Idle at random outside the steady stretch, then hold the word until it is
  // taken. Log the expected word at the accepting edge.
  task automatic send_ray(input ray_t ray, input bend_t want);
    while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    incidence_x_i <= ray.ix;
    incidence_y_i <= ray.iy;
    incidence_z_i <= ray.iz;
    normal_x_i    <= ray.nx;
    normal_y_i    <= ray.ny;
    normal_z_i    <= ray.nz;
    index_ratio_i <= ray.ratio;
    do @(posedge clk_i); while (!in_ready_o);
    expected_bends.push_back(want);
  endtask

  task automatic note_mismatch(input string msg);
    $display("mismatch at cycle %0d: %s", cycles, msg);
    mismatches++;
  endtask

  initial begin
    ray_t ray;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // walk the directed table first
    foreach (directed_rows[i]) begin
      send_ray(directed_rows[i].ray,
               directed_rows[i].known ? directed_rows[i].want
                                      : refract(directed_rows[i].ray));
    end

    for (int n = 0; n < RANDOM_RAYS; n++) begin
      // drop valid once and let the pipe drain completely
      if (n == PAUSE_AT) begin
        in_valid_i <= 1'b0;
        do @(posedge clk_i); while (expected_bends.size() != 0);
      end
      // run a stretch at full rate on both sides
      steady = (n >= STEADY_LO) && (n < STEADY_HI);
      ray = draw_ray();
      send_ray(ray, refract(ray));
    end
    in_valid_i <= 1'b0;
    steady = 1'b0;

    // drain, then give the pipe time to show any stray word
    while (expected_bends.size() != 0) @(posedge clk_i);
    repeat (PIPE_DEPTH + 8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

  // receiver stalls at random, except during the steady stretch
  always @(posedge clk_i) begin
    out_ready_i <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  // compare every accepted word with the oldest expectation
  always @(posedge clk_i) begin
    bend_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_bends.size() == 0) begin
        note_mismatch("result word with nothing expected");
      end else begin
        want = expected_bends.pop_front();
        if (refracted_ok_o !== want.ok)
          note_mismatch($sformatf("refracted_ok got %0b expected %0b",
                                  refracted_ok_o, want.ok));
        if (refracted_x_o !== want.tx)
          note_mismatch($sformatf("refracted_x got %0d expected %0d",
                                  refracted_x_o, want.tx));
        if (refracted_y_o !== want.ty)
          note_mismatch($sformatf("refracted_y got %0d expected %0d",
                                  refracted_y_o, want.ty));
        if (refracted_z_o !== want.tz)
          note_mismatch($sformatf("refracted_z got %0d expected %0d",
                                  refracted_z_o, want.tz));
      end
    end
  end

  // hang guard
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/srv_pkg.sv
rtl/core/srv_front.sv
rtl/core/srv_sqrt.sv
rtl/core/srv_back.sv
rtl/core/snell_refraction_vector.sv
rtl/core/srv_checker.sv
verif/testbench.sv
